// File: rtl/itbs_pkg.sv
// Package of the ICMP token bucket screen: item types, cell control types,
// reason codes, sequencer states and fixed widths. Depends on nothing.
package itbs_pkg;

   localparam int ADDR_W = 32;
   localparam int TTL_W = 8;
   localparam int PROTO_W = 8;
   localparam int TIME_W = 64;
   localparam int RATE_W = 20;
   localparam int TOKEN_W = 32;
   localparam int REASON_W = 2;
   localparam int ELAPSED_W = 30;
   localparam int PRODUCT_W = ELAPSED_W + RATE_W;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam int DEFAULT_ENTRIES = 64;
   localparam logic [RATE_W-1:0] RESET_RATE = RATE_W'(100);
   localparam logic [TIME_W-1:0] NS_PER_SECOND = TIME_W'(64'd1000000000);
   localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;
   localparam logic [PROTO_W-1:0] PROTO_ICMP = PROTO_W'(1);
   localparam logic [CSR_AW-1:0] REG_ICMP_RATE = '0;

   localparam logic [REASON_W-1:0] REASON_NONE = 2'd0;
   localparam logic [REASON_W-1:0] REASON_ZERO_ADDR = 2'd1;
   localparam logic [REASON_W-1:0] REASON_ZERO_TTL = 2'd2;
   localparam logic [REASON_W-1:0] REASON_ICMP_RATE = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]  source_address;
      logic [ADDR_W-1:0]  dest_address;
      logic [TTL_W-1:0]   time_to_live;
      logic [PROTO_W-1:0] protocol_number;
      logic [TIME_W-1:0]  now_ns;
   } req_type;

   typedef struct packed {
      logic                verdict;
      logic [REASON_W-1:0] drop_reason;
   } rsp_type;

   typedef struct packed {
      logic               match_en;
      logic               upd_en;
      logic               insert;
      logic               wr_en;
      logic [ADDR_W-1:0]  key;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  stamp;
   } cell_ctl_type;

   typedef struct packed {
      logic               hit;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  stamp;
   } cell_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ELAPSED,
      ST_MULT,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } itbs_state_type;

endpackage

// File: rtl/itbs_cell.sv
// One bucket cell: key, token count, time stamp, validity and LRU rank.
// Depends on itbs_pkg.
module itbs_cell import itbs_pkg::*; #(
   parameter int RW = 6,
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [RW-1:0]     sel_rank,
   output cell_out_type      cell_out,
   output logic [RW-1:0]     rank_out
);

   logic               valid_ff;
   logic               hit_ff;
   logic [RW-1:0]      rank_ff;
   logic [ADDR_W-1:0]  src_ff;
   logic [TOKEN_W-1:0] tokens_ff;
   logic [TIME_W-1:0]  stamp_ff;
   logic               chosen;

   assign chosen = ctl.insert ? (rank_ff == sel_rank) : hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff <= 1'b0;
         rank_ff <= RW'(INDEX);
      end else begin
         if (ctl.match_en) begin
            hit_ff <= valid_ff && (src_ff == ctl.key);
         end
         if (ctl.upd_en) begin
            if (chosen) begin
               rank_ff <= '0;
            end else if (rank_ff < sel_rank) begin
               rank_ff <= rank_ff + RW'(1);
            end
            if (chosen && ctl.insert) begin
               valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd_en && chosen && (ctl.insert || ctl.wr_en)) begin
         src_ff <= ctl.key;
         tokens_ff <= ctl.tokens;
         stamp_ff <= ctl.stamp;
      end
   end

   assign cell_out.hit = hit_ff;
   assign cell_out.tokens = hit_ff ? tokens_ff : '0;
   assign cell_out.stamp = hit_ff ? stamp_ff : '0;
   assign rank_out = hit_ff ? rank_ff : '0;

endmodule

// File: rtl/itbs_divider.sv
// Division of the refill product by one second in nanoseconds, by a shift and a
// reciprocal multiplication of four partial products. Depends on itbs_pkg.
module itbs_divider import itbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PRODUCT_W-1:0] dividend,
   output logic                 done,
   output logic [RATE_W-1:0]    quotient
);

   // One second is 2^9 * 5^9. The dividend is shifted right by nine and then
   // multiplied by 2^62 / 5^9 rounded up, which is exact below 2^41. The
   // product is formed from four 21 by 21 bit partial products, one a cycle.
   localparam int SHIFT_IN = 9;
   localparam int NUM_W = PRODUCT_W - SHIFT_IN;
   localparam int HALF_W = 21;
   localparam int PART_W = 2 * HALF_W;
   localparam int RECIP_W = 42;
   localparam int ACC_W = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT = 62;
   localparam logic [RECIP_W-1:0] RECIP = 42'd2361183241435;
   localparam logic [1:0] LAST_STEP = 2'd3;

   logic                 busy_ff;
   logic                 done_ff;
   logic [1:0]           step_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [HALF_W-1:0]    op_a;
   logic [HALF_W-1:0]    op_b;
   logic [PART_W-1:0]    part;
   logic [ACC_W-1:0]     part_aligned;

   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = num_ff[HALF_W-1:0];
            op_b = RECIP[HALF_W-1:0];
         end
         2'd1: begin
            op_a = num_ff[HALF_W-1:0];
            op_b = RECIP[RECIP_W-1:HALF_W];
         end
         2'd2: begin
            op_a = HALF_W'(num_ff[NUM_W-1:HALF_W]);
            op_b = RECIP[HALF_W-1:0];
         end
         default: begin
            op_a = HALF_W'(num_ff[NUM_W-1:HALF_W]);
            op_b = RECIP[RECIP_W-1:HALF_W];
         end
      endcase
      part = PART_W'(op_a) * PART_W'(op_b);
      case (step_ff)
         2'd0: begin
            part_aligned = ACC_W'(part);
         end
         2'd1, 2'd2: begin
            part_aligned = ACC_W'(part) << HALF_W;
         end
         default: begin
            part_aligned = ACC_W'(part) << PART_W;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == LAST_STEP)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend[PRODUCT_W-1:SHIFT_IN];
         acc_ff <= '0;
         step_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + part_aligned;
         step_ff <= step_ff + 2'd1;
      end
   end

   assign done = done_ff;
   assign quotient = acc_ff[RECIP_SHIFT +: RATE_W];

endmodule

// File: rtl/icmp_token_bucket_screen_core.sv
// ICMP token bucket screen: header checks and a per-source ICMP rate limiter.
// Depends on itbs_pkg, itbs_cell and itbs_divider.
// One item is taken at a time; the next is not taken until the result of the
// last has been handed to the output register. A packet that fails or passes on
// its header alone, or any non-ICMP packet, goes straight to its result; a new
// ICMP source is looked up and inserted first. A known ICMP source is looked up,
// its elapsed time and product are formed, the divider forms the refill quotient
// from four partial products of a reciprocal multiplication, and its bucket is
// updated. The buckets live in a row of cells, one per entry, that match the key
// in parallel and keep their own LRU rank; no clearing pass is needed.
module icmp_token_bucket_screen_core import itbs_pkg::*; #(
   parameter int BUCKET_ENTRIES = DEFAULT_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int RW = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
   localparam int FW = $clog2(BUCKET_ENTRIES + 1);

   itbs_state_type       state_ff, state_in;
   logic [RATE_W-1:0]    rate_ff;
   req_type              item_ff;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic [FW-1:0]        fill_ff;
   logic                 hit_any_ff;
   logic [TOKEN_W-1:0]   hit_tokens_ff;
   logic [TIME_W-1:0]    hit_stamp_ff;
   logic [RW-1:0]        hit_rank_ff;
   logic [TIME_W-1:0]    elapsed_ff;
   logic                 full_ff;
   logic                 accept;
   logic                 is_icmp;
   rsp_type              check_res;
   cell_ctl_type         ctl;
   logic [RW-1:0]        sel_rank;
   logic [RW-1:0]        fill_rank;
   cell_out_type         cells_out [BUCKET_ENTRIES];
   logic [RW-1:0]        cells_rank [BUCKET_ENTRIES];
   logic                 bus_hit;
   logic [TOKEN_W-1:0]   bus_tokens;
   logic [TIME_W-1:0]    bus_stamp;
   logic [RW-1:0]        bus_rank;
   logic                 div_start;
   logic                 div_done;
   logic [RATE_W-1:0]    div_q;
   logic [PRODUCT_W-1:0] product;
   logic [TOKEN_W:0]     level_sum;
   logic [TOKEN_W:0]     level;

   assign pready = 1'b1;
   assign prdata = CSR_DW'(rate_ff);
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RESET_RATE;
      end else if (psel && penable && pwrite && (paddr == REG_ICMP_RATE)) begin
         rate_ff <= pwdata[RATE_W-1:0];
      end
   end

   always_comb begin
      is_icmp = 1'b0;
      check_res.verdict = 1'b0;
      check_res.drop_reason = REASON_NONE;
      if ((req_data.source_address == '0) || (req_data.dest_address == '0)) begin
         check_res.verdict = 1'b1;
         check_res.drop_reason = REASON_ZERO_ADDR;
      end else if (req_data.dest_address == ADDR_ALL_ONES) begin
         check_res.verdict = 1'b0;
      end else if (req_data.time_to_live == '0) begin
         check_res.verdict = 1'b1;
         check_res.drop_reason = REASON_ZERO_TTL;
      end else if (req_data.protocol_number == PROTO_ICMP) begin
         is_icmp = 1'b1;
      end
   end

   always_comb begin
      bus_hit = 1'b0;
      bus_tokens = '0;
      bus_stamp = '0;
      bus_rank = '0;
      for (int i = 0; i < BUCKET_ENTRIES; i++) begin
         bus_hit = bus_hit | cells_out[i].hit;
         bus_tokens = bus_tokens | cells_out[i].tokens;
         bus_stamp = bus_stamp | cells_out[i].stamp;
         bus_rank = bus_rank | cells_rank[i];
      end
   end

   assign fill_rank = (fill_ff == FW'(BUCKET_ENTRIES)) ? RW'(BUCKET_ENTRIES - 1)
                                                        : fill_ff[RW-1:0];
   assign product = PRODUCT_W'(elapsed_ff[ELAPSED_W-1:0]) * PRODUCT_W'(rate_ff);
   assign level_sum = (TOKEN_W+1)'(hit_tokens_ff) + (TOKEN_W+1)'(div_q);

   always_comb begin
      if (full_ff || (level_sum > (TOKEN_W+1)'(rate_ff))) begin
         level = (TOKEN_W+1)'(rate_ff);
      end else begin
         level = level_sum;
      end
   end

   always_comb begin
      state_in = state_ff;
      res_in = res_ff;
      div_start = 1'b0;
      ctl.match_en = 1'b0;
      ctl.upd_en = 1'b0;
      ctl.insert = 1'b0;
      ctl.wr_en = 1'b0;
      ctl.key = (state_ff == ST_IDLE) ? req_data.source_address : item_ff.source_address;
      ctl.tokens = TOKEN_W'(rate_ff);
      ctl.stamp = item_ff.now_ns;
      sel_rank = fill_rank;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = check_res;
               ctl.match_en = is_icmp;
               state_in = is_icmp ? ST_LOOKUP : ST_DONE;
            end
         end
         ST_LOOKUP: begin
            if (bus_hit) begin
               state_in = ST_ELAPSED;
            end else begin
               ctl.upd_en = 1'b1;
               ctl.insert = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_ELAPSED: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            div_start = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sel_rank = hit_rank_ff;
            ctl.upd_en = 1'b1;
            ctl.wr_en = (level != '0);
            ctl.tokens = TOKEN_W'(level - (TOKEN_W+1)'(1));
            if (level == '0) begin
               res_in.verdict = 1'b1;
               res_in.drop_reason = REASON_ICMP_RATE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.upd_en && ctl.insert && (fill_ff != FW'(BUCKET_ENTRIES))) begin
            fill_ff <= fill_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_any_ff <= bus_hit;
         hit_tokens_ff <= bus_tokens;
         hit_stamp_ff <= bus_stamp;
         hit_rank_ff <= bus_rank;
      end
      if (state_ff == ST_ELAPSED) begin
         elapsed_ff <= item_ff.now_ns - hit_stamp_ff;
      end
      if (state_ff == ST_MULT) begin
         full_ff <= elapsed_ff >= NS_PER_SECOND;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff <= res_ff;
      end
   end

   for (genvar g = 0; g < BUCKET_ENTRIES; g++) begin : g_cell
      itbs_cell #(
         .RW(RW),
         .INDEX(g)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .sel_rank(sel_rank),
         .cell_out(cells_out[g]),
         .rank_out(cells_rank[g])
      );
   end

   itbs_divider u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(product),
      .done(div_done),
      .quotient(div_q)
   );

`ifndef ASSERT_OFF
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken while an item is in progress");
   a_reason_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.verdict == (rsp_data.drop_reason != REASON_NONE)))
      else $error("verdict and drop reason disagree");
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FW'(BUCKET_ENTRIES)) && (fill_ff >= $past(fill_ff)))
      else $error("table fill count out of order");
   a_update_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> hit_any_ff)
      else $error("bucket update without a table hit");
`endif

endmodule
